### design/sgpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sgpm_pkg;

  localparam int PATTERN_MAX_DEF = 64;
  localparam int CHAR_W = 8;
  localparam int ACT_W = 2;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CHAR   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_END    = 2'd3;

  localparam logic [CHAR_W-1:0] STAR_BYTE  = 8'h2A;
  localparam logic [CHAR_W-1:0] DOT_BYTE   = 8'h2E;
  localparam logic [CHAR_W-1:0] SLASH_BYTE = 8'h2F;

  typedef struct packed {
    logic              clear;
    logic              wr;
    logic              wr_start;
    logic              restart;
    logic              step;
    logic [CHAR_W-1:0] wchar;
    logic [CHAR_W-1:0] cchar;
  } sgpm_ctl_t;

  function automatic logic [CHAR_W-1:0] map_byte(input logic [CHAR_W-1:0] b);
    return (b == DOT_BYTE) ? SLASH_BYTE : b;
  endfunction

endpackage

`default_nettype wire

### design/sgpm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface sgpm_in_if;
  logic                        valid;
  logic                        ready;
  logic [sgpm_pkg::ACT_W-1:0]  action;
  logic [sgpm_pkg::CHAR_W-1:0] character;
  modport source(output valid, output action, output character, input ready);
  modport sink(input valid, input action, input character, output ready);
endinterface

interface sgpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;
  modport source(output valid, output matched, output pattern_overflow, input ready);
  modport sink(input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

### design/sgpm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sgpm_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 7
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sgpm_pkg::sgpm_ctl_t ctl,
  input  wire logic [LEN_W-1:0]    len,
  input  wire logic                carry_in,
  output logic                     carry_out,
  output logic                     end_hit
);

  localparam logic [LEN_W:0] IDX_L = (LEN_W + 1)'(IDX);
  localparam logic START_RST = (IDX == 0);

  logic [sgpm_pkg::CHAR_W-1:0] char_r;
  logic                        start_r;
  logic                        start_nxt;
  logic                        act_r;
  logic                        act_nxt;
  logic                        valid;
  logic                        is_star;
  logic                        nxt_pos;
  logic [LEN_W:0]              len_x;

  assign len_x   = {1'b0, len};
  assign valid   = IDX_L < len_x;
  assign is_star = (char_r == sgpm_pkg::STAR_BYTE);

  // A star position stays live and passes its activity on to the next position.
  assign nxt_pos   = carry_in | (act_r & valid & is_star);
  assign carry_out = valid & ((act_r & !is_star & (char_r == ctl.cchar)) | (nxt_pos & is_star));
  assign end_hit   = act_r & (IDX_L == len_x);

  always_comb begin
    if (ctl.clear) begin
      start_nxt = START_RST;
    end else if (ctl.wr && (IDX_L == len_x + 1'b1)) begin
      start_nxt = ctl.wr_start;
    end else begin
      start_nxt = start_r;
    end
  end

  always_comb begin
    if (ctl.restart) begin
      act_nxt = start_nxt;
    end else if (ctl.step) begin
      act_nxt = nxt_pos;
    end else begin
      act_nxt = act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RST;
      act_r   <= START_RST;
    end else begin
      start_r <= start_nxt;
      act_r   <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && (IDX_L == len_x)) begin
      char_r <= ctl.wchar;
    end
  end

endmodule

`default_nettype wire

### design/star_glob_path_matcher.sv
// Star-only glob matcher for path strings.
// Input channel in_ch carries an action and a byte. Clear empties the pattern,
// append adds one pattern byte, a candidate byte advances the match, and an
// end word returns one result word on out_ch: matched and pattern_overflow.
// A '.' is treated as '/' both in the pattern and in the candidate.
// An input word can be accepted on every clock while no result waits on a
// stalled receiver. The match state lives in a row of PATTERN_MAX + 1 cells,
// one per pattern position, and a candidate byte ripples through that row in
// the same cycle. The result word shows in the cycle after its end word.
// The output register accepts a new input word while the previous result is
// taken in the same cycle; while the receiver stalls with a result pending,
// in_ch.ready is low and the block holds its state.
// After reset the pattern is empty, the overflow flag is clear and every
// candidate matches. Pattern bytes beyond PATTERN_MAX are dropped and raise
// pattern_overflow until the next clear.
`timescale 1ns / 1ps
`default_nettype none

module star_glob_path_matcher #(
  parameter int PATTERN_MAX = sgpm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sgpm_in_if.sink     in_ch,
  sgpm_out_if.source  out_ch
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_MAX);

  logic                        accept;
  logic                        full;
  logic                        hit;
  logic [sgpm_pkg::CHAR_W-1:0] mapped;
  logic                        mapped_star;
  logic [LEN_W-1:0]            len_r;
  logic [LEN_W-1:0]            len_nxt;
  logic                        ovf_r;
  logic                        ovf_nxt;
  logic                        all_star_r;
  logic                        all_star_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        matched_r;
  logic                        do_clear;
  logic                        do_append;
  logic                        do_char;
  logic                        do_end;
  sgpm_pkg::sgpm_ctl_t         ctl;
  logic [PATTERN_MAX+1:0]      carry;
  logic [PATTERN_MAX:0]        end_hits;

  assign in_ch.ready             = !out_valid_r || out_ch.ready;
  assign accept                  = in_ch.valid && in_ch.ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.matched          = matched_r;
  assign out_ch.pattern_overflow = ovf_r;

  assign mapped      = sgpm_pkg::map_byte(in_ch.character);
  assign mapped_star = (mapped == sgpm_pkg::STAR_BYTE);
  assign full        = (len_r == LEN_FULL);

  always_comb begin
    do_clear  = 1'b0;
    do_append = 1'b0;
    do_char   = 1'b0;
    do_end    = 1'b0;
    unique case (in_ch.action)
      sgpm_pkg::ACT_CLEAR:  do_clear  = accept;
      sgpm_pkg::ACT_APPEND: do_append = accept;
      sgpm_pkg::ACT_CHAR:   do_char   = accept;
      sgpm_pkg::ACT_END:    do_end    = accept;
      default: ;
    endcase
  end

  always_comb begin
    ctl.clear    = do_clear;
    ctl.wr       = do_append && !full;
    ctl.wr_start = all_star_r && mapped_star;
    ctl.restart  = do_clear || do_append || do_end;
    ctl.step     = do_char;
    ctl.wchar    = mapped;
    ctl.cchar    = mapped;
  end

  always_comb begin
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    all_star_nxt = all_star_r;
    if (do_clear) begin
      len_nxt      = '0;
      ovf_nxt      = 1'b0;
      all_star_nxt = 1'b1;
    end else if (do_append) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt      = len_r + 1'b1;
        all_star_nxt = all_star_r && mapped_star;
      end
    end
  end

  assign carry[0] = 1'b0;

  for (genvar g = 0; g <= PATTERN_MAX; g++) begin : g_cell
    sgpm_cell #(
      .IDX   (g),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .len       (len_r),
      .carry_in  (carry[g]),
      .carry_out (carry[g+1]),
      .end_hit   (end_hits[g])
    );
  end

  assign hit = (len_r == '0) || (|end_hits);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      all_star_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      all_star_r  <= all_star_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_end) begin
      matched_r <= hit;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_FULL)
    else $error("pattern length beyond capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> (len_r == '0) && !ovf_r)
    else $error("clear did not empty the pattern");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    do_end |=> out_valid_r)
    else $error("end word gave no result");

  a_ovf_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(do_append && full))
    else $error("overflow raised without a dropped byte");

  a_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
    !carry[PATTERN_MAX+1])
    else $error("activity passed beyond the last position");

endmodule

`default_nettype wire

### tb/tb_star_glob_path_matcher.sv
`timescale 1ns / 1ps

module tb_star_glob_path_matcher;

  localparam int PMAX = sgpm_pkg::PATTERN_MAX_DEF;
  localparam int ITEM_TARGET = 1350;
  localparam int TAIL_START = ITEM_TARGET - 200;
  localparam int STALL_LIMIT = 2000;
  localparam logic [sgpm_pkg::CHAR_W-1:0] CH_A = 8'h61;
  localparam logic [sgpm_pkg::CHAR_W-1:0] CH_B = 8'h62;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } verdict_t;

  class glob_scoreboard;
    logic [sgpm_pkg::CHAR_W-1:0] pat_bytes [PMAX];
    int unsigned pat_len;
    logic [PMAX:0] live;
    bit overflowed;
    verdict_t verdicts[$];
    int unsigned mismatches;
    int unsigned words_seen;
    int unsigned results_seen;
    int unsigned hits;
    int unsigned overflow_results;

    function new();
      pat_len = 0;
      overflowed = 1'b0;
      live = '0;
      live[0] = 1'b1;
      mismatches = 0;
      words_seen = 0;
      results_seen = 0;
      hits = 0;
      overflow_results = 0;
    endfunction

    function logic [sgpm_pkg::CHAR_W-1:0] fold_dot(logic [sgpm_pkg::CHAR_W-1:0] b);
      return (b == sgpm_pkg::DOT_BYTE) ? sgpm_pkg::SLASH_BYTE : b;
    endfunction

    // A live star position also makes the position after it live.
    function logic [PMAX:0] close_stars(logic [PMAX:0] v);
      logic [PMAX:0] r;
      r = v;
      for (int i = 0; i < pat_len; i++) begin
        if (r[i] && pat_bytes[i] == sgpm_pkg::STAR_BYTE) r[i+1] = 1'b1;
      end
      return r;
    endfunction

    function void restart();
      live = '0;
      live[0] = 1'b1;
    endfunction

    function void step_char(logic [sgpm_pkg::CHAR_W-1:0] c);
      logic [PMAX:0] nxt;
      nxt = '0;
      live = close_stars(live);
      for (int i = 0; i < pat_len; i++) begin
        if (live[i]) begin
          if (pat_bytes[i] == sgpm_pkg::STAR_BYTE) nxt[i] = 1'b1;
          else if (pat_bytes[i] == c) nxt[i+1] = 1'b1;
        end
      end
      live = close_stars(nxt);
    endfunction

    function void note_word(logic [sgpm_pkg::ACT_W-1:0] act,
                            logic [sgpm_pkg::CHAR_W-1:0] ch);
      verdict_t v;
      words_seen++;
      case (act)
        sgpm_pkg::ACT_CLEAR: begin
          pat_len = 0;
          overflowed = 1'b0;
          restart();
        end
        sgpm_pkg::ACT_APPEND: begin
          if (pat_len < PMAX) begin
            pat_bytes[pat_len] = fold_dot(ch);
            pat_len++;
          end else begin
            overflowed = 1'b1;
          end
          restart();
        end
        sgpm_pkg::ACT_CHAR: begin
          step_char(fold_dot(ch));
        end
        sgpm_pkg::ACT_END: begin
          live = close_stars(live);
          v.matched = (pat_len == 0) || live[pat_len];
          v.pattern_overflow = overflowed;
          verdicts.insert(verdicts.size(), v);
          restart();
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic m, logic o);
      verdict_t want;
      results_seen++;
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: matched=%0b overflow=%0b", m, o);
        return;
      end
      want = verdicts.pop_front();
      if (want.matched) hits++;
      if (want.pattern_overflow) overflow_results++;
      if (m !== want.matched || o !== want.pattern_overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result %0d: expected matched=%0b overflow=%0b, %s=%0b overflow=%0b",
                   results_seen, want.matched, want.pattern_overflow, "got matched",
                   m, o);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit tail_part = 1'b0;
  int gap_pct = 10;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  glob_scoreboard board = new();

  sgpm_in_if in_ch();
  sgpm_out_if out_ch();

  star_glob_path_matcher dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.matched, out_ch.pattern_overflow);
      if (in_ch.valid && in_ch.ready)
        board.note_word(in_ch.action, in_ch.character);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : result_sink
    int stall_left;
    int stall_pct;
    int span;
    stall_left = 0;
    stall_pct = 10;
    span = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (span == 0) begin
        span = $urandom_range(50, 200);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      span--;
      if (stall_left == 0 && !tail_part && $urandom_range(0, 99) < stall_pct)
        stall_left = $urandom_range(1, 16);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [sgpm_pkg::ACT_W-1:0] act,
                           input logic [sgpm_pkg::CHAR_W-1:0] ch);
    int gap;
    gap = 0;
    if (!tail_part && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 16);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.character <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    if (words_sent >= TAIL_START) tail_part = 1'b1;
  endtask

  function automatic logic [sgpm_pkg::CHAR_W-1:0] rand_byte();
    logic [31:0] r;
    r = $urandom();
    return r[sgpm_pkg::CHAR_W-1:0];
  endfunction

  function automatic logic [sgpm_pkg::ACT_W-1:0] rand_act();
    logic [31:0] r;
    r = $urandom();
    return r[sgpm_pkg::ACT_W-1:0];
  endfunction

  function automatic logic [sgpm_pkg::CHAR_W-1:0] pick_glyph(input bit allow_star);
    case ($urandom_range(0, 9))
      0, 1, 2: return CH_A;
      3: return CH_B;
      4: return sgpm_pkg::DOT_BYTE;
      5: return sgpm_pkg::SLASH_BYTE;
      6: return allow_star ? sgpm_pkg::STAR_BYTE : CH_A;
      default: return rand_byte();
    endcase
  endfunction

  // One pattern, then candidates shaped after it, some of them broken.
  task automatic run_phase();
    int plen;
    int used;
    int ncand;
    int pos;
    logic [sgpm_pkg::CHAR_W-1:0] pat_q[$];
    logic [sgpm_pkg::CHAR_W-1:0] cand_q[$];
    gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
    send_word(sgpm_pkg::ACT_CLEAR, rand_byte());
    plen = ($urandom_range(0, 11) == 0) ? $urandom_range(PMAX - 4, PMAX + 6)
                                         : $urandom_range(0, 8);
    for (int i = 0; i < plen; i++) begin
      pat_q.insert(pat_q.size(), pick_glyph(1'b1));
      send_word(sgpm_pkg::ACT_APPEND, pat_q[i]);
    end
    used = (plen > PMAX) ? PMAX : plen;
    ncand = (plen > PMAX - 8) ? 2 : $urandom_range(1, 6);
    repeat (ncand) begin
      cand_q.delete();
      for (int i = 0; i < used; i++) begin
        if (pat_q[i] == sgpm_pkg::STAR_BYTE) begin
          repeat ($urandom_range(0, 3)) cand_q.insert(cand_q.size(), pick_glyph(1'b0));
        end else if (pat_q[i] == sgpm_pkg::DOT_BYTE || pat_q[i] == sgpm_pkg::SLASH_BYTE) begin
          cand_q.insert(cand_q.size(),
                        $urandom_range(0, 1) ? sgpm_pkg::DOT_BYTE : sgpm_pkg::SLASH_BYTE);
        end else begin
          cand_q.insert(cand_q.size(), pat_q[i]);
        end
      end
      if (cand_q.size() > 0 && $urandom_range(0, 3) == 0) begin
        pos = $urandom_range(0, cand_q.size() - 1);
        case ($urandom_range(0, 2))
          0: cand_q[pos] = pick_glyph(1'b1);
          1: cand_q.delete(pos);
          default: cand_q.insert(pos, pick_glyph(1'b1));
        endcase
      end
      foreach (cand_q[i]) send_word(sgpm_pkg::ACT_CHAR, cand_q[i]);
      if ($urandom_range(0, 9) == 0) send_word(rand_act(), rand_byte());
      send_word(sgpm_pkg::ACT_END, rand_byte());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = sgpm_pkg::ACT_CLEAR;
    in_ch.character = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty pattern, with an empty and a one-byte candidate.
    send_word(sgpm_pkg::ACT_END, 8'hFF);
    send_word(sgpm_pkg::ACT_CHAR, 8'hFF);
    send_word(sgpm_pkg::ACT_END, 8'h00);
    // A lone star against an empty candidate.
    send_word(sgpm_pkg::ACT_APPEND, sgpm_pkg::STAR_BYTE);
    send_word(sgpm_pkg::ACT_END, 8'h00);
    // Dot folding on both sides, a star and a zero byte.
    send_word(sgpm_pkg::ACT_CLEAR, 8'hFF);
    send_word(sgpm_pkg::ACT_APPEND, sgpm_pkg::DOT_BYTE);
    send_word(sgpm_pkg::ACT_APPEND, sgpm_pkg::STAR_BYTE);
    send_word(sgpm_pkg::ACT_APPEND, 8'h00);
    send_word(sgpm_pkg::ACT_CHAR, sgpm_pkg::SLASH_BYTE);
    send_word(sgpm_pkg::ACT_CHAR, CH_A);
    send_word(sgpm_pkg::ACT_CHAR, 8'h00);
    send_word(sgpm_pkg::ACT_END, 8'h00);
    send_word(sgpm_pkg::ACT_CHAR, sgpm_pkg::DOT_BYTE);
    send_word(sgpm_pkg::ACT_END, 8'h00);
    // An append in the middle of a candidate restarts it.
    send_word(sgpm_pkg::ACT_CHAR, 8'hFF);
    send_word(sgpm_pkg::ACT_APPEND, 8'hFF);
    send_word(sgpm_pkg::ACT_CHAR, sgpm_pkg::DOT_BYTE);
    send_word(sgpm_pkg::ACT_CHAR, 8'h00);
    send_word(sgpm_pkg::ACT_CHAR, 8'hFF);
    send_word(sgpm_pkg::ACT_END, 8'h00);
    send_word(sgpm_pkg::ACT_CLEAR, 8'h00);
    send_word(sgpm_pkg::ACT_END, 8'h00);

    while (words_sent < ITEM_TARGET) run_phase();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d input words and %0d result words (%0d matches, %0d with overflow).",
             board.words_seen, board.results_seen, board.hits, board.overflow_results);
    if (board.mismatches == 0 && board.verdicts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d", board.mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
